[rtl/slas_pkg.sv]
package slas_pkg;

  // request kinds on the input channel
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // line control characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEND = 3'b010,
    ST_FAIL = 3'b100
  } state_t;

endpackage

[rtl/serial_line_assembler_unit.sv]
// Serial line assembler. Received bytes (req_type 0) are taken one per cycle
// while in_stall is low and give no beat; carriage return is ignored, line feed
// ends the line. Lines live in one memory split into two banks: the build bank
// and the ready bank swap on a line feed that commits a line, so no copy is
// made. A read request (req_type 1) is accepted, then the line streams out one
// beat per cycle while out_stall is low (N beats for an N-byte line), paced by
// the registered read port of the line memory; a failed read gives one beat
// with ok low. While a read is streaming, in_stall stays high. Line length
// limit is LINE_MAX_LEN-1 bytes; a longer line is dropped up to its line feed.
module serial_line_assembler_unit #(
  parameter int LINE_MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  input  logic [7:0] dest_capacity,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       ok,
  output logic [7:0] data_byte,
  output logic       last
);

  localparam int CW = (LINE_MAX_LEN > 2) ? $clog2(LINE_MAX_LEN) : 1;
  localparam int AW = CW + 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(LINE_MAX_LEN - 1);

  slas_pkg::state_t state, state_next;

  logic [CW-1:0] build_count, build_count_next;
  logic          discard_flag, discard_flag_next;
  logic          build_bank, build_bank_next;
  logic [CW-1:0] ready_length, ready_length_next;
  logic          ready_flag, ready_flag_next;
  logic [CW-1:0] rd_idx, rd_idx_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic in_beat;
  logic out_beat;
  logic is_last;
  logic fits;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;
  assign is_last  = ((AW)'(rd_idx) + 1'b1) == (AW)'(ready_length);
  assign fits     = ready_flag && (ready_length != '0) &&
                    ((9'(ready_length) + 9'd1) <= 9'(dest_capacity));

  // port view of the sequencer
  assign in_stall  = (state != slas_pkg::ST_IDLE);
  assign out_valid = (state == slas_pkg::ST_SEND) || (state == slas_pkg::ST_FAIL);
  assign ok        = (state == slas_pkg::ST_SEND);
  assign data_byte = (state == slas_pkg::ST_SEND) ? mem_rdata : slas_pkg::CH_NUL;
  assign last      = (state == slas_pkg::ST_FAIL) ||
                     ((state == slas_pkg::ST_SEND) && is_last);

  // byte intake and read sequencing
  always_comb begin
    state_next        = state;
    build_count_next  = build_count;
    discard_flag_next = discard_flag;
    build_bank_next   = build_bank;
    ready_length_next = ready_length;
    ready_flag_next   = ready_flag;
    rd_idx_next       = rd_idx;
    mem_we            = 1'b0;
    mem_waddr         = {build_bank, build_count};
    mem_re            = 1'b0;
    mem_raddr         = {!build_bank, rd_idx};

    unique case (state)
      slas_pkg::ST_IDLE: begin
        if (in_beat && req_type == slas_pkg::REQ_READ) begin
          if (fits) begin
            rd_idx_next = '0;
            mem_re      = 1'b1;
            mem_raddr   = {!build_bank, {CW{1'b0}}};
            state_next  = slas_pkg::ST_SEND;
          end else begin
            state_next = slas_pkg::ST_FAIL;
          end
        end else if (in_beat) begin
          if (rx_byte == slas_pkg::CH_LF) begin
            // commit by swapping banks when the slot is free
            if (build_count != '0 && !discard_flag && !ready_flag) begin
              ready_length_next = build_count;
              ready_flag_next   = 1'b1;
              build_bank_next   = !build_bank;
            end
            build_count_next  = '0;
            discard_flag_next = 1'b0;
          end else if (rx_byte != slas_pkg::CH_CR && !discard_flag) begin
            if (build_count < FULL_COUNT) begin
              mem_we           = 1'b1;
              build_count_next = build_count + 1'b1;
            end else begin
              discard_flag_next = 1'b1;
              build_count_next  = '0;
            end
          end
        end
      end
      slas_pkg::ST_SEND: begin
        if (out_beat) begin
          if (is_last) begin
            ready_flag_next = 1'b0;
            state_next      = slas_pkg::ST_IDLE;
          end else begin
            rd_idx_next = rd_idx + 1'b1;
            mem_re      = 1'b1;
            mem_raddr   = {!build_bank, rd_idx + 1'b1};
          end
        end
      end
      slas_pkg::ST_FAIL: begin
        if (out_beat) begin
          state_next = slas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slas_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= slas_pkg::ST_IDLE;
      build_count  <= '0;
      discard_flag <= 1'b0;
      build_bank   <= 1'b0;
      ready_length <= '0;
      ready_flag   <= 1'b0;
      rd_idx       <= '0;
    end else begin
      state        <= state_next;
      build_count  <= build_count_next;
      discard_flag <= discard_flag_next;
      build_bank   <= build_bank_next;
      ready_length <= ready_length_next;
      ready_flag   <= ready_flag_next;
      rd_idx       <= rd_idx_next;
    end
  end

  // both line banks
  slas_line_mem #(
    .AW(AW)
  ) u_line_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(rx_byte),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

[rtl/slas_line_mem.sv]
module slas_line_mem #(
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  // one write port, one registered read port; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/slas_checker.sv]
module slas_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       req_type,
  input logic       out_valid,
  input logic       out_stall,
  input logic       ok,
  input logic [7:0] data_byte,
  input logic       last
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ok) && $stable(data_byte) &&
    $stable(last))
    else $error("result beat changed while stalled");

  // a failure beat is a single zero beat
  a_fail_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> last && data_byte == 8'h00)
    else $error("failure beat malformed");

  // no new request is taken while a read is still streaming
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during a read");

  // an accepted read answers in the next cycle
  a_read_answer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type |=> out_valid)
    else $error("read request gave no beat");

  // reset leaves no beat pending
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind serial_line_assembler_unit slas_checker u_slas_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .req_type (req_type),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .ok       (ok),
  .data_byte(data_byte),
  .last     (last)
);

[tb/sv/serial_line_assembler_unit_tb.sv]
`timescale 1ns / 100ps

module serial_line_assembler_unit_tb;

  localparam int LINE_MAX_LEN = 64;
  localparam int RANDOM_ITEMS = 360;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  // one output beat
  typedef struct packed {
    logic       ok;
    logic [7:0] data_byte;
    logic       last;
  } line_beat_t;

  // tracks line assembly and the ready slot, holds the beats still to come
  class line_tracker;
    logic [7:0] build_mem [LINE_MAX_LEN];
    int         build_len;
    bit         discarding;
    logic [7:0] ready_mem [LINE_MAX_LEN];
    int         ready_len;
    bit         ready_valid;
    line_beat_t pending_beats [$];
    int         errors;

    function void apply_request(logic req, logic [7:0] ch, logic [7:0] cap);
      line_beat_t b;
      if (req == slas_pkg::REQ_BYTE) begin
        if (ch == slas_pkg::CH_LF) begin
          // end of line: commit into an empty slot, else drop
          if (build_len > 0 && !discarding && !ready_valid) begin
            for (int i = 0; i < build_len; i++) ready_mem[i] = build_mem[i];
            ready_len = build_len;
            ready_valid = 1'b1;
          end
          build_len = 0;
          discarding = 1'b0;
        end else if (ch != slas_pkg::CH_CR && !discarding) begin
          // ordinary byte, overflow starts discarding up to the line feed
          if (build_len < LINE_MAX_LEN - 1) begin
            build_mem[build_len] = ch;
            build_len++;
          end else begin
            discarding = 1'b1;
            build_len = 0;
          end
        end
      end else if (!ready_valid || ready_len == 0 || ready_len >= LINE_MAX_LEN ||
                   ready_len + 1 > int'(cap)) begin
        // no line or reader buffer too small
        b.ok = 1'b0;
        b.data_byte = slas_pkg::CH_NUL;
        b.last = 1'b1;
        pending_beats.push_back(b);
      end else begin
        for (int i = 0; i < ready_len; i++) begin
          b.ok = 1'b1;
          b.data_byte = ready_mem[i];
          b.last = (i + 1 == ready_len);
          pending_beats.push_back(b);
        end
        ready_valid = 1'b0;
      end
    endfunction

    function void match_beat(logic ok_got, logic [7:0] data_got, logic last_got);
      line_beat_t b;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: ok %0d data_byte %0h last %0d", ok_got, data_got, last_got);
        errors++;
      end else begin
        b = pending_beats.pop_front();
        if (ok_got !== b.ok) begin
          $error("ok: expected %0d, got %0d", b.ok, ok_got);
          errors++;
        end
        if (data_got !== b.data_byte) begin
          $error("data_byte: expected %0h, got %0h", b.data_byte, data_got);
          errors++;
        end
        if (last_got !== b.last) begin
          $error("last: expected %0d, got %0d", b.last, last_got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       req_type = slas_pkg::REQ_BYTE;
  logic [7:0] rx_byte = slas_pkg::CH_NUL;
  logic [7:0] dest_capacity = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       ok;
  logic [7:0] data_byte;
  logic       last;

  line_tracker sb = new();

  bit tx_idle_on = 1'b0;
  bit rx_stall_on = 1'b0;
  int idle_pct = 73;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int quiet_cycles = 0;

  serial_line_assembler_unit #(
    .LINE_MAX_LEN(LINE_MAX_LEN)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .rx_byte(rx_byte),
    .dest_capacity(dest_capacity),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ok(ok),
    .data_byte(data_byte),
    .last(last)
  );

  // clock
  always #5 clk = ~clk;

  // beats accepted on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.apply_request(req_type, rx_byte, dest_capacity);
      if (out_valid && !out_stall) sb.match_beat(ok, data_byte, last);
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver: random stall, or a long hold-off on request
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= rx_stall_on && ($urandom_range(99) < idle_pct);
        @(negedge clk);
      end
    end
  end

  // present one beat at a falling edge and hold it until taken
  task automatic send_beat(logic req, logic [7:0] ch, logic [7:0] cap);
    bit taken;
    while (tx_idle_on && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    rx_byte <= ch;
    dest_capacity <= cap;
    if (!(req == slas_pkg::REQ_BYTE && ch == slas_pkg::CH_CR)) items_sent++;
    do begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
  endtask

  function automatic logic [7:0] line_char();
    logic [7:0] c;
    c = 8'($urandom);
    if (c == slas_pkg::CH_LF) c = slas_pkg::CH_NUL;
    return c;
  endfunction

  // a line of random content, optional stray carriage returns
  task automatic send_line(int len, bit crlf);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) begin
        send_beat(slas_pkg::REQ_BYTE, slas_pkg::CH_CR, 8'($urandom));
      end
      send_beat(slas_pkg::REQ_BYTE, line_char(), 8'($urandom));
    end
    if (crlf) send_beat(slas_pkg::REQ_BYTE, slas_pkg::CH_CR, 8'($urandom));
    send_beat(slas_pkg::REQ_BYTE, slas_pkg::CH_LF, 8'($urandom));
  endtask

  // read with a capacity around the ready line length
  task automatic read_line();
    int len;
    int r;
    logic [7:0] cap;
    len = sb.ready_valid ? sb.ready_len : $urandom_range(1, 63);
    r = $urandom_range(99);
    if (r < 10) cap = 8'd0;
    else if (r < 20) cap = 8'(len);
    else if (r < 35) cap = 8'(len + 1);
    else if (r < 50) cap = 8'd255;
    else cap = 8'($urandom_range(len + 1, 255));
    send_beat(slas_pkg::REQ_READ, 8'($urandom), cap);
  endtask

  initial begin
    int base;
    int p;
    int r;
    int len;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty slot, capacity edges, zero and 0xff data
    send_beat(slas_pkg::REQ_READ, 8'hFF, 8'd255);
    send_beat(slas_pkg::REQ_BYTE, 8'h41, 8'd0);
    send_beat(slas_pkg::REQ_BYTE, slas_pkg::CH_CR, 8'd0);
    send_beat(slas_pkg::REQ_BYTE, slas_pkg::CH_NUL, 8'hFF);
    send_beat(slas_pkg::REQ_BYTE, 8'hFF, 8'd0);
    send_beat(slas_pkg::REQ_BYTE, slas_pkg::CH_LF, 8'd0);
    send_beat(slas_pkg::REQ_READ, 8'd0, 8'd3);
    send_beat(slas_pkg::REQ_READ, 8'd0, 8'd0);
    send_beat(slas_pkg::REQ_READ, 8'd0, 8'd4);
    send_beat(slas_pkg::REQ_READ, 8'd0, 8'd255);
    // empty line, then a second line dropped while the slot is taken
    send_beat(slas_pkg::REQ_BYTE, slas_pkg::CH_LF, 8'd0);
    send_beat(slas_pkg::REQ_READ, 8'd0, 8'd255);
    send_beat(slas_pkg::REQ_BYTE, 8'h78, 8'd0);
    send_beat(slas_pkg::REQ_BYTE, slas_pkg::CH_LF, 8'd0);
    send_beat(slas_pkg::REQ_BYTE, 8'h79, 8'd0);
    send_beat(slas_pkg::REQ_BYTE, slas_pkg::CH_LF, 8'd0);
    send_beat(slas_pkg::REQ_READ, 8'd0, 8'd2);

    // long receiver hold-off while a read streams and bytes keep coming
    for (int i = 0; i < 50; i++) send_beat(slas_pkg::REQ_BYTE, 8'(8'h61 + i % 26), 8'd0);
    send_beat(slas_pkg::REQ_BYTE, slas_pkg::CH_LF, 8'd0);
    in_valid <= 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    wait (!hold_req);
    send_beat(slas_pkg::REQ_READ, 8'd0, 8'd255);
    for (int i = 0; i < 10; i++) send_beat(slas_pkg::REQ_BYTE, 8'(8'h30 + i), 8'd0);
    send_beat(slas_pkg::REQ_BYTE, slas_pkg::CH_LF, 8'd0);

    // random lines and reads, with noise, across idling phases
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      p = (items_sent - base) * 5 / RANDOM_ITEMS;
      tx_idle_on = (p == 1 || p == 3);
      rx_stall_on = (p == 2 || p == 3);
      // both sides idle together at a lower rate
      idle_pct = (p == 3) ? 31 : 73;
      r = $urandom_range(99);
      if (r < 15) begin
        send_beat(1'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        r = $urandom_range(99);
        if (r < 70) len = $urandom_range(1, 8);
        else if (r < 80) len = $urandom_range(9, 40);
        else if (r < 88) len = $urandom_range(LINE_MAX_LEN - 2, LINE_MAX_LEN - 1);
        else if (r < 94) len = $urandom_range(LINE_MAX_LEN, LINE_MAX_LEN + 6);
        else len = 0;
        send_line(len, $urandom_range(2) == 0);
        if ($urandom_range(3) != 0) read_line();
      end
    end
    in_valid <= 1'b0;
    tx_idle_on = 1'b0;

    // drain outstanding beats, then a quiet tail
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
